>>> hdl/ddpd_pkg.sv
// Shared types, constants and microcode table of the differential-drive PD controller.
package ddpd_pkg;

  localparam int CountW = 16;
  localparam int GainW  = 16;
  localparam int IrW    = 12;
  localparam int DriveW = 16;
  localparam int WallW  = 14;
  localparam int ErrW   = 24;
  localparam int BaseW  = 18;
  localparam int MulAW  = GainW + 1;
  localparam int MulBW  = ErrW + 1;
  localparam int ProdW  = MulAW + MulBW;
  localparam int AccW   = ProdW + 2;
  localparam int DistW  = 14;
  localparam int PcW    = 4;
  localparam int CfgIdxW = 4;

  // wall sensing
  localparam logic [IrW-1:0]         LeftWallLevel  = 12'd1500;
  localparam logic [IrW-1:0]         RightWallLevel = 12'd1000;
  localparam logic signed [WallW-1:0] IrLeftMid     = 14'sd2000;
  localparam logic signed [WallW-1:0] IrRightMid    = 14'sd1300;

  localparam logic signed [AccW-1:0] WallRound  = 44'sd2048;
  localparam int                     WallShift  = 12;
  localparam logic signed [AccW-1:0] DistLimit  = 44'sd4096;
  localparam logic signed [ErrW-1:0] DoneCounts = 24'sd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegGoalDistance = 4'd0;
  localparam logic [CfgIdxW-1:0] RegGoalAngle    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegKpAngle      = 4'd2;
  localparam logic [CfgIdxW-1:0] RegKdAngle      = 4'd3;
  localparam logic [CfgIdxW-1:0] RegKpDist       = 4'd4;
  localparam logic [CfgIdxW-1:0] RegKdDist       = 4'd5;
  localparam logic [CfgIdxW-1:0] RegKpWall       = 4'd6;
  localparam logic [CfgIdxW-1:0] RegKdWall       = 4'd7;

  localparam logic [GainW-1:0] KpAngleReset = 16'd287;
  localparam logic [GainW-1:0] KdAngleReset = 16'd3072;
  localparam logic [GainW-1:0] KpDistReset  = 16'd123;
  localparam logic [GainW-1:0] KdDistReset  = 16'd0;
  localparam logic [GainW-1:0] KpWallReset  = 16'd287;
  localparam logic [GainW-1:0] KdWallReset  = 16'd2867;

  typedef struct packed {
    logic signed [CountW-1:0] goal_distance;
    logic signed [CountW-1:0] goal_angle;
    logic [GainW-1:0]         kp_angle;
    logic [GainW-1:0]         kd_angle;
    logic [GainW-1:0]         kp_dist;
    logic [GainW-1:0]         kd_dist;
    logic [GainW-1:0]         kp_wall;
    logic [GainW-1:0]         kd_wall;
  } cfg_t;

  typedef enum logic [2:0] {
    A_KP_WALL, A_KD_WALL, A_KP_ANGLE, A_KD_ANGLE, A_KP_DIST, A_KD_DIST
  } a_sel_t;

  typedef enum logic [2:0] {
    B_WALL, B_DWALL, B_AE, B_DAE, B_DE, B_DDE
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef struct packed {
    a_sel_t           a_sel;
    b_sel_t           b_sel;
    acc_op_t          acc_op;
    logic             prep;        // latch wall error, base angle and distance errors
    logic             wall_fix;    // subtract rounded wall term from angle error
    logic             save_wall;
    logic             save_acorr;
    logic             finish;      // drives out, error history and done flag
    logic             br_no_dist;  // jump to target when no distance goal
    logic [PcW-1:0]   target;
  } ctrl_t;

  localparam ctrl_t CtrlNop = '{a_sel: A_KP_WALL, b_sel: B_WALL, acc_op: ACC_HOLD,
                                prep: 1'b0, wall_fix: 1'b0, save_wall: 1'b0,
                                save_acorr: 1'b0, finish: 1'b0, br_no_dist: 1'b0,
                                target: '0};

  localparam logic [PcW-1:0] PcAngle = 4'd5;

  // Multiplier products land one step after selection; the accumulator uses them then.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = CtrlNop;
    unique case (pc)
      4'd0: begin
        c.prep = 1'b1; c.br_no_dist = 1'b1; c.target = PcAngle;
      end
      4'd1: begin
        c.a_sel = A_KP_WALL; c.b_sel = B_WALL;
      end
      4'd2: begin
        c.a_sel = A_KD_WALL; c.b_sel = B_DWALL; c.acc_op = ACC_LOAD;
      end
      4'd3: c.acc_op = ACC_ADD;
      4'd4: c.wall_fix = 1'b1;
      4'd5: begin
        c.a_sel = A_KP_ANGLE; c.b_sel = B_AE; c.save_wall = 1'b1;
      end
      4'd6: begin
        c.a_sel = A_KD_ANGLE; c.b_sel = B_DAE; c.acc_op = ACC_LOAD;
      end
      4'd7: begin
        c.a_sel = A_KP_DIST; c.b_sel = B_DE; c.acc_op = ACC_ADD;
      end
      4'd8: begin
        c.a_sel = A_KD_DIST; c.b_sel = B_DDE; c.acc_op = ACC_LOAD; c.save_acorr = 1'b1;
      end
      4'd9: c.acc_op = ACC_ADD;
      4'd10: c.finish = 1'b1;
      default: c.finish = 1'b1;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/ddpd_datapath.sv
// Datapath: error registers, shared multiplier, accumulator and output shaping.
module ddpd_datapath
  import ddpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [CountW-1:0] left_count,
  input  logic signed [CountW-1:0] right_count,
  input  logic [IrW-1:0]           ir_left,
  input  logic [IrW-1:0]           ir_right,
  input  cfg_t                     cfg,
  input  logic                     step_en,
  input  ctrl_t                    ctrl,
  output logic signed [DriveW-1:0] left_drive,
  output logic signed [DriveW-1:0] right_drive,
  output logic                     done_next
);

  logic signed [CountW-1:0] lc;
  logic signed [CountW-1:0] rc;
  logic [IrW-1:0]           irl;
  logic [IrW-1:0]           irr;

  logic signed [WallW-1:0] wall_error;
  logic signed [WallW-1:0] prev_wall_error;
  logic signed [ErrW-1:0]  prev_angle_error;
  logic signed [ErrW-1:0]  prev_dist_error;
  logic                    done_flag;

  logic signed [ErrW-1:0]  ae;
  logic signed [ErrW-1:0]  de2;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acorr;

  logic signed [WallW-1:0] lerr;
  logic signed [WallW-1:0] rerr;
  logic                    lseen;
  logic                    rseen;
  logic signed [WallW-1:0] wall_next;
  logic signed [BaseW-1:0] ae_base;
  logic signed [BaseW-1:0] de2_base;
  logic signed [MulAW-1:0] a_op;
  logic signed [MulBW-1:0] b_op;
  logic signed [AccW-1:0]  wall_term;
  logic signed [DistW-1:0] dist_clamp;
  logic signed [DistW-1:0] dist_half;
  logic signed [AccW:0]    left_sum;
  logic signed [AccW:0]    right_sum;

  function automatic logic signed [DriveW-1:0] sat16(input logic signed [AccW:0] v);
    if (v > (AccW+1)'(32767)) begin
      return 16'sh7fff;
    end else if (v < -(AccW+1)'(32768)) begin
      return 16'sh8000;
    end
    return v[DriveW-1:0];
  endfunction

  assign lerr  = $signed({2'b00, irl}) - IrLeftMid;
  assign rerr  = $signed({2'b00, irr}) - IrRightMid;
  assign lseen = irl > LeftWallLevel;
  assign rseen = irr > RightWallLevel;

  always_comb begin
    priority if (lseen && rseen) begin
      wall_next = rerr - lerr;
    end else if (lseen) begin
      wall_next = -lerr;
    end else if (rseen) begin
      wall_next = rerr;
    end else begin
      wall_next = wall_error;
    end
  end

  assign ae_base  = BaseW'(cfg.goal_angle) - (BaseW'(lc) - BaseW'(rc));
  assign de2_base = (BaseW'(cfg.goal_distance) + BaseW'(cfg.goal_distance))
                  - (BaseW'(lc) + BaseW'(rc));

  always_comb begin
    unique case (ctrl.a_sel)
      A_KP_WALL:  a_op = $signed({1'b0, cfg.kp_wall});
      A_KD_WALL:  a_op = $signed({1'b0, cfg.kd_wall});
      A_KP_ANGLE: a_op = $signed({1'b0, cfg.kp_angle});
      A_KD_ANGLE: a_op = $signed({1'b0, cfg.kd_angle});
      A_KP_DIST:  a_op = $signed({1'b0, cfg.kp_dist});
      A_KD_DIST:  a_op = $signed({1'b0, cfg.kd_dist});
      default:    a_op = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      B_WALL:  b_op = MulBW'(wall_error);
      B_DWALL: b_op = MulBW'(wall_error) - MulBW'(prev_wall_error);
      B_AE:    b_op = MulBW'(ae);
      B_DAE:   b_op = MulBW'(ae) - MulBW'(prev_angle_error);
      B_DE:    b_op = MulBW'(de2);
      B_DDE:   b_op = MulBW'(de2) - MulBW'(prev_dist_error);
      default: b_op = '0;
    endcase
  end

  // round half up, then to whole counts
  assign wall_term = (acc + WallRound) >>> WallShift;

  always_comb begin
    priority if (acc > DistLimit) begin
      dist_clamp = DistW'(DistLimit);
    end else if (acc < -DistLimit) begin
      dist_clamp = -DistW'(DistLimit);
    end else begin
      dist_clamp = acc[DistW-1:0];
    end
  end

  assign dist_half   = (dist_clamp + DistW'(1)) >>> 1;
  assign left_sum    = (AccW+1)'(dist_half) + (AccW+1)'(acorr);
  assign right_sum   = (AccW+1)'(dist_half) - (AccW+1)'(acorr);
  assign left_drive  = sat16(left_sum);
  assign right_drive = sat16(right_sum);

  always_comb begin
    done_next = done_flag;
    if (cfg.goal_angle == '0 && cfg.goal_distance != '0) begin
      if (de2 > -(DoneCounts + DoneCounts) && de2 < (DoneCounts + DoneCounts)) begin
        done_next = 1'b1;
      end
    end else if (cfg.goal_distance == '0 && cfg.goal_angle != '0) begin
      if (ae > -DoneCounts && ae < DoneCounts) begin
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lc  <= left_count;
      rc  <= right_count;
      irl <= ir_left;
      irr <= ir_right;
    end
    if (step_en) begin
      prod <= ProdW'(a_op) * ProdW'(b_op);
      unique case (ctrl.acc_op)
        ACC_LOAD: acc <= AccW'(prod);
        ACC_ADD:  acc <= acc + AccW'(prod);
        default:  acc <= acc;
      endcase
      if (ctrl.prep) begin
        ae  <= ErrW'(ae_base);
        de2 <= ErrW'(de2_base);
      end else if (ctrl.wall_fix) begin
        ae <= ae - wall_term[ErrW-1:0];
      end
      if (ctrl.save_acorr) begin
        acorr <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_error       <= '0;
      prev_wall_error  <= '0;
      prev_angle_error <= '0;
      prev_dist_error  <= '0;
      done_flag        <= 1'b0;
    end else if (step_en) begin
      if (ctrl.prep) begin
        wall_error <= wall_next;
      end
      if (ctrl.save_wall) begin
        prev_wall_error <= wall_error;
      end
      if (ctrl.finish) begin
        prev_angle_error <= ae;
        prev_dist_error  <= de2;
        done_flag        <= done_next;
      end
    end
  end

endmodule

>>> hdl/differential_drive_pd_controller_unit.sv
// Top level: configuration registers, microcode sequencer and stream handshakes.
//
// One input transfer per control tick on s_*: encoder counts and IR readings.
// One result transfer per tick on m_*: left and right drive (signed Q3.12,
// saturated) and the sticky done flag.
// The cfg_* channel writes goals and Q4.12 gains by register index 0..7;
// other indexes are ignored. Write only while no tick is in flight.
// A microcode program of up to 11 steps runs on one shared 17x25 multiplier
// and accumulator: 7 steps when goal_distance is zero (wall term skipped),
// 11 otherwise. The result becomes valid as the last step completes, and
// s_tready returns in the same cycle.
// The result waits in an output register; the next tick is accepted and
// computed meanwhile and only its last step stalls while m_tready is low.
// Reset clears the sequencer, the error history, the held wall error and the
// done flag, and loads the default goals and gains; done is cleared only by
// reset.
module differential_drive_pd_controller_unit
  import ddpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [GainW-1:0]   cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [55:0]        s_tdata,  // left_count, right_count, ir_left, ir_right
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata   // left_drive, right_drive, done_res, zero pad
);

  cfg_t             cfg;
  logic             busy;
  logic [PcW-1:0]   pc;
  logic [PcW-1:0]   pc_next;
  ctrl_t            ctrl;
  logic             accept;
  logic             step_en;

  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;
  logic                     done_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign accept    = s_tvalid && !busy;
  assign ctrl      = ucode(pc);
  assign step_en   = busy && !(ctrl.finish && m_tvalid && !m_tready);

  always_comb begin
    if (ctrl.br_no_dist && cfg.goal_distance == '0) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PcW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_distance <= '0;
      cfg.goal_angle    <= '0;
      cfg.kp_angle      <= KpAngleReset;
      cfg.kd_angle      <= KdAngleReset;
      cfg.kp_dist       <= KpDistReset;
      cfg.kd_dist       <= KdDistReset;
      cfg.kp_wall       <= KpWallReset;
      cfg.kd_wall       <= KdWallReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegGoalDistance: cfg.goal_distance <= $signed(cfg_data);
        RegGoalAngle:    cfg.goal_angle    <= $signed(cfg_data);
        RegKpAngle:      cfg.kp_angle      <= cfg_data;
        RegKdAngle:      cfg.kd_angle      <= cfg_data;
        RegKpDist:       cfg.kp_dist       <= cfg_data;
        RegKdDist:       cfg.kd_dist       <= cfg_data;
        RegKpWall:       cfg.kp_wall       <= cfg_data;
        RegKdWall:       cfg.kd_wall       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (step_en) begin
      if (ctrl.finish) begin
        busy <= 1'b0;
      end
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_en && ctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && ctrl.finish) begin
      m_tdata <= {7'b0, done_next, right_drive, left_drive};
    end
  end

  ddpd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .left_count  ($signed(s_tdata[15:0])),
    .right_count ($signed(s_tdata[31:16])),
    .ir_left     (s_tdata[43:32]),
    .ir_right    (s_tdata[55:44]),
    .cfg         (cfg),
    .step_en     (step_en),
    .ctrl        (ctrl),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .done_next   (done_next)
  );

endmodule
